// ===== hw/rtl/track_point_summary_stats_core_macros.svh =====
// Assertion macros for the track point summary statistics core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TRACK_POINT_SUMMARY_STATS_CORE_MACROS_SVH
`define TRACK_POINT_SUMMARY_STATS_CORE_MACROS_SVH
// implication checked on every edge outside reset
`define TPS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("tps check failed");
// next-cycle implication outside reset
`define TPS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("tps check failed");
`endif

// ===== hw/rtl/tpss_pkg.sv =====
// Package for the track point summary statistics core.
// Shared widths, channel codes, queue entry type. No dependencies.
package tpss_pkg;
  localparam int PointCountBitsDefault = 20;
  localparam int ValW = 20;
  localparam int SumW = 36;
  localparam int GlW = 32;
  localparam int AvgW = 16;
  localparam logic signed [ValW-1:0] MostNeg = 20'sh80000;
  localparam logic signed [ValW-1:0] MostPos = 20'sh7FFFF;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef enum logic [1:0] {
    CH_CAD = 2'd0,
    CH_HR  = 2'd1,
    CH_SPD = 2'd2,
    CH_ELE = 2'd3
  } chan_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic [7:0]            cad;
    logic [7:0]            hr;
    logic [15:0]           spd;
    logic signed [ValW-1:0] ele;
    logic                  first;
    logic                  lap_end;
    logic                  act_end;
  } item_t;
endpackage

// ===== hw/rtl/tpss_front.sv =====
// Front part: accepts samples, classifies end marks and queues them.
// Depends on tpss_pkg.
module tpss_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          cadence_rpm,
  input  logic [7:0]          heart_bpm,
  input  logic [15:0]         speed_mms,
  input  logic signed [19:0]  elevation_dm,
  input  logic                first_of_activity,
  input  logic                last_of_lap,
  input  logic                last_of_activity,
  output logic                q_valid,
  output tpss_pkg::item_t     q_item,
  input  logic                q_pop
);
  import tpss_pkg::*;
  `include "track_point_summary_stats_core_macros.svh"

  item_t slot [2];
  logic  wp, rp;
  logic [1:0] fill;
  logic  push;

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != 2'd0);
  assign q_item = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= '{cad: cadence_rpm, hr: heart_bpm, spd: speed_mms, ele: elevation_dm,
                    first: first_of_activity, lap_end: last_of_lap | last_of_activity,
                    act_end: last_of_activity};
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

  `TPS_ASSERT_IMP(a_no_pop_empty, clk, rst, q_pop, fill != 2'd0)
  `TPS_ASSERT_IMP(a_no_push_full, clk, rst, push, fill != 2'd2)
  `TPS_ASSERT_IMP(a_act_lap, clk, rst, q_valid && q_item.act_end, q_item.lap_end)
endmodule

// ===== hw/rtl/tpss_div.sv =====
// Restoring divider, one quotient bit per cycle, for row averages.
// Depends on tpss_pkg.
module tpss_div #(
  parameter int PointCountBits = tpss_pkg::PointCountBitsDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tpss_pkg::SumW-1:0] dividend,
  input  logic [PointCountBits-1:0] divisor,
  output logic                      busy,
  output logic [tpss_pkg::AvgW-1:0] quotient
);
  import tpss_pkg::*;
  localparam int CntW = $clog2(SumW + 1);

  logic [SumW-1:0]           q;
  logic [PointCountBits:0]   r;
  logic [PointCountBits-1:0] d;
  logic [CntW-1:0]           cnt;
  logic [PointCountBits:0]   trial;

  assign trial = {r[PointCountBits-1:0], q[SumW-1]};
  assign busy = (cnt != '0);
  // saturate: any quotient bit above the average width forces all ones
  assign quotient = (d == '0) ? '0 :
                    ((|q[SumW-1:AvgW]) ? {AvgW{1'b1}} : q[AvgW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
      cnt <= CntW'(SumW);
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        r <= trial - {1'b0, d};
        q <= {q[SumW-2:0], 1'b1};
      end else begin
        r <= trial;
        q <= {q[SumW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end
  end
endmodule

// ===== hw/rtl/tpss_back.sv =====
// Back part: folds samples into lap and activity statistics and emits rows.
// Depends on tpss_pkg and tpss_div.
module tpss_back #(
  parameter int PointCountBits = tpss_pkg::PointCountBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  tpss_pkg::item_t       q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  scope,
  output logic [1:0]            channel,
  output logic signed [19:0]    maximum,
  output logic signed [19:0]    minimum,
  output logic [15:0]           average,
  output logic [31:0]           gain_dm,
  output logic [31:0]           loss_dm,
  output logic                  last_row
);
  import tpss_pkg::*;
  `include "track_point_summary_stats_core_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  logic signed [ValW-1:0] mx [2][4];
  logic signed [ValW-1:0] mn [2][4];
  logic [SumW-1:0] sm [2][3];
  logic [PointCountBits-1:0] cnt [2];
  logic [GlW-1:0] gl [2][2];
  logic signed [ValW-1:0] prev;
  logic have_prev;
  logic cur_scope, act_pend;
  logic [1:0] cur_ch;
  logic div_start, div_busy;
  logic [AvgW-1:0] div_q;
  logic signed [ValW:0] diff;
  logic [GlW-1:0] up, down;
  logic signed [ValW-1:0] v [4];

  assign v[0] = ValW'($signed({1'b0, q_item.cad}));
  assign v[1] = ValW'($signed({1'b0, q_item.hr}));
  assign v[2] = ValW'($signed({1'b0, q_item.spd}));
  assign v[3] = q_item.ele;

  always_comb begin
    diff = {q_item.ele[ValW-1], q_item.ele} - {prev[ValW-1], prev};
    up = '0;
    down = '0;
    if (have_prev && !q_item.first) begin
      if (diff > 0) up = GlW'(diff);
      else down = GlW'(-diff);
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  tpss_div #(.PointCountBits(PointCountBits)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend((cur_ch == CH_ELE) ? '0 : sm[cur_scope][cur_ch]),
    .divisor(cnt[cur_scope]), .busy(div_busy), .quotient(div_q)
  );
  assign div_start = (state == S_DIV);

  function automatic logic [GlW-1:0] sat32(input logic [GlW-1:0] a, input logic [GlW-1:0] b);
    logic [GlW:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[GlW] ? {GlW{1'b1}} : t[GlW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      have_prev <= 1'b0;
      prev <= '0;
      for (int s = 0; s < 2; s++) begin
        for (int c = 0; c < 4; c++) begin
          mx[s][c] <= MostNeg;
          mn[s][c] <= MostPos;
        end
        for (int c = 0; c < 3; c++) sm[s][c] <= '0;
        cnt[s] <= '0;
        gl[s][0] <= '0;
        gl[s][1] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            // fold into both scopes; a new activity starts from cleared state
            for (int s = 0; s < 2; s++) begin
              for (int c = 0; c < 4; c++) begin
                logic signed [ValW-1:0] bmx, bmn;
                bmx = q_item.first ? MostNeg : mx[s][c];
                bmn = q_item.first ? MostPos : mn[s][c];
                mx[s][c] <= (v[c] > bmx) ? v[c] : bmx;
                mn[s][c] <= ((v[c] < bmn) && !(c == 1 && v[c] == 0)) ? v[c] : bmn;
              end
              for (int c = 0; c < 3; c++) begin
                logic [SumW:0] t;
                t = {1'b0, (q_item.first ? '0 : sm[s][c])} + (SumW+1)'(unsigned'(v[c]));
                sm[s][c] <= t[SumW] ? SumMax : t[SumW-1:0];
              end
              begin
                logic [PointCountBits-1:0] bc;
                bc = q_item.first ? '0 : cnt[s];
                cnt[s] <= (&bc) ? bc : bc + 1'b1;
              end
              gl[s][0] <= sat32(q_item.first ? '0 : gl[s][0], up);
              gl[s][1] <= sat32(q_item.first ? '0 : gl[s][1], down);
            end
            prev <= q_item.ele;
            have_prev <= 1'b1;
            act_pend <= q_item.act_end;
            cur_ch <= CH_CAD;
            cur_scope <= q_item.lap_end ? 1'b0 : 1'b1;
            if (q_item.lap_end || q_item.act_end) state <= S_DIV;
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (!div_busy && !out_valid) state <= S_OUT;
        end
        S_OUT: begin
          logic signed [ValW-1:0] rmx, rmn;
          logic fin;
          rmx = mx[cur_scope][cur_ch];
          rmn = mn[cur_scope][cur_ch];
          if (cur_ch != CH_ELE) begin
            if (rmx == MostNeg) rmx = '0;
            if (rmn == MostPos) rmn = '0;
          end
          fin = (cur_ch == CH_ELE) && (cur_scope || !act_pend);
          out_valid <= 1'b1;
          scope <= cur_scope;
          channel <= cur_ch;
          maximum <= rmx;
          minimum <= rmn;
          average <= (cur_ch == CH_ELE) ? '0 : div_q;
          gain_dm <= (cur_ch == CH_ELE) ? gl[cur_scope][0] : '0;
          loss_dm <= (cur_ch == CH_ELE) ? gl[cur_scope][1] : '0;
          last_row <= fin;
          if (cur_ch == CH_ELE) begin
            // clear the scope just reported
            for (int c = 0; c < 4; c++) begin
              mx[cur_scope][c] <= MostNeg;
              mn[cur_scope][c] <= MostPos;
            end
            for (int c = 0; c < 3; c++) sm[cur_scope][c] <= '0;
            cnt[cur_scope] <= '0;
            gl[cur_scope][0] <= '0;
            gl[cur_scope][1] <= '0;
            if (cur_scope) begin
              have_prev <= 1'b0;
              prev <= '0;
            end
            if (fin) begin
              state <= S_IDLE;
            end else begin
              cur_scope <= 1'b1;
              cur_ch <= CH_CAD;
              state <= S_DIV;
            end
          end else begin
            cur_ch <= cur_ch + 2'd1;
            state <= S_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TPS_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, state == S_IDLE)
  `TPS_ASSERT_IMP(a_out_free, clk, rst, state == S_OUT, !out_valid && !div_busy)
  `TPS_ASSERT_NEXT(a_div_busy, clk, rst, state == S_DIV, div_busy)
endmodule

// ===== hw/rtl/track_point_summary_stats_core.sv =====
// Track point summary statistics core: lap and activity min/max/mean/gain.
// A sample is queued and folded once the back is idle. Each row of a closing sample then
// passes divide, wait and output states, waiting for the bit-serial average divider (36
// quotient bits, one per cycle) and for a free output register. Throughput: a lap end
// gives 4 rows, an activity end 8; other samples go one per cycle, when the back is idle,
// through a two-beat queue. Reset (rst, sync, active high) clears stats, baseline, queue.
module track_point_summary_stats_core #(
  parameter int PointCountBits = tpss_pkg::PointCountBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         cadence_rpm,
  input  logic [7:0]         heart_bpm,
  input  logic [15:0]        speed_mms,
  input  logic signed [19:0] elevation_dm,
  input  logic               first_of_activity,
  input  logic               last_of_lap,
  input  logic               last_of_activity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               scope,
  output logic [1:0]         channel,
  output logic signed [19:0] maximum,
  output logic signed [19:0] minimum,
  output logic [15:0]        average,
  output logic [31:0]        gain_dm,
  output logic [31:0]        loss_dm,
  output logic               last_row
);
  import tpss_pkg::*;

  // queue between front and back: each beat is one classified sample
  logic  q_valid, q_pop;
  item_t q_item;

  // front: accept and classify beats, hold them until the back is free
  tpss_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .cadence_rpm(cadence_rpm), .heart_bpm(heart_bpm), .speed_mms(speed_mms),
    .elevation_dm(elevation_dm), .first_of_activity(first_of_activity),
    .last_of_lap(last_of_lap), .last_of_activity(last_of_activity),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // back: fold, then divide and emit summary rows through the output register
  tpss_back #(.PointCountBits(PointCountBits)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .scope(scope), .channel(channel),
    .maximum(maximum), .minimum(minimum), .average(average),
    .gain_dm(gain_dm), .loss_dm(loss_dm), .last_row(last_row)
  );
endmodule

// ===== sim/track_point_summary_stats_checker.sv =====
`timescale 1ns / 1ps
// Checker for the track point summary statistics core: watches both channels,
// folds accepted samples into its own lap/activity statistics and compares rows.
// Depends on tpss_pkg for widths, limits and channel codes.
module track_point_summary_stats_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         cadence_rpm,
  input  logic [7:0]         heart_bpm,
  input  logic [15:0]        speed_mms,
  input  logic signed [19:0] elevation_dm,
  input  logic               first_of_activity,
  input  logic               last_of_lap,
  input  logic               last_of_activity,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               scope,
  input  logic [1:0]         channel,
  input  logic signed [19:0] maximum,
  input  logic signed [19:0] minimum,
  input  logic [15:0]        average,
  input  logic [31:0]        gain_dm,
  input  logic [31:0]        loss_dm,
  input  logic               last_row,
  output int                 mismatches,
  output int                 rows_pending
);
  import tpss_pkg::*;

  localparam int CountBits = PointCountBitsDefault;

  typedef struct packed {
    logic              scope;
    chan_t             channel;
    logic signed [19:0] maximum;
    logic signed [19:0] minimum;
    logic [15:0]       average;
    logic [31:0]       gain;
    logic [31:0]       loss;
    logic              last_row;
  } summary_row_t;

  typedef struct {
    logic signed [ValW-1:0] maxima [4];
    logic signed [ValW-1:0] minima [4];
    logic [SumW-1:0]        sums [3];
    logic [CountBits-1:0]   count;
    logic [GlW-1:0]         gain;
    logic [GlW-1:0]         loss;
  } track_stats_t;

  track_stats_t lap_acc, act_acc;
  logic signed [ValW-1:0] prev_ele;
  logic have_prev;
  summary_row_t summary_rows [$];

  function automatic track_stats_t cleared_stats();
    track_stats_t s;
    for (int i = 0; i < 4; i++) begin
      s.maxima[i] = MostNeg;
      s.minima[i] = MostPos;
    end
    for (int i = 0; i < 3; i++) s.sums[i] = '0;
    s.count = '0;
    s.gain = '0;
    s.loss = '0;
    return s;
  endfunction

  function automatic logic [GlW-1:0] add_sat32(logic [GlW-1:0] a, logic [GlW-1:0] b);
    logic [GlW:0] t;
    t = a + b;
    return t[GlW] ? '1 : t[GlW-1:0];
  endfunction

  function automatic track_stats_t fold_sample(track_stats_t s, int v[4],
                                               logic [GlW-1:0] up, logic [GlW-1:0] down);
    logic [SumW:0] t;
    for (int i = 0; i < 4; i++) begin
      if (v[i] > s.maxima[i]) s.maxima[i] = v[i];
      // a zero heart rate is no reading: never lowers the minimum
      if (!(i == CH_HR && v[i] == 0) && v[i] < s.minima[i]) s.minima[i] = v[i];
    end
    for (int i = 0; i < 3; i++) begin
      t = s.sums[i] + v[i];
      s.sums[i] = t[SumW] ? SumMax : t[SumW-1:0];
    end
    if (s.count != '1) s.count++;
    s.gain = add_sat32(s.gain, up);
    s.loss = add_sat32(s.loss, down);
    return s;
  endfunction

  task automatic queue_rows(track_stats_t s, logic sc, logic final_set);
    summary_row_t r;
    logic [SumW-1:0] q;
    for (int ch = 0; ch < 4; ch++) begin
      r.scope = sc;
      r.channel = chan_t'(ch);
      r.maximum = s.maxima[ch];
      r.minimum = s.minima[ch];
      r.average = '0;
      if (ch != CH_ELE) begin
        if (r.maximum == MostNeg) r.maximum = '0;
        if (r.minimum == MostPos) r.minimum = '0;
        if (s.count != 0) begin
          q = s.sums[ch] / s.count;
          r.average = (q > 65535) ? 16'hFFFF : q[15:0];
        end
      end
      r.gain = (ch == CH_ELE) ? s.gain : '0;
      r.loss = (ch == CH_ELE) ? s.loss : '0;
      r.last_row = final_set && ch == CH_ELE;
      summary_rows.push_back(r);
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic absorb_sample();
    int v[4];
    int d;
    logic [GlW-1:0] up, down;
    logic lap_end;
    v[0] = cadence_rpm;
    v[1] = heart_bpm;
    v[2] = speed_mms;
    v[3] = elevation_dm;
    lap_end = last_of_lap || last_of_activity;
    up = '0;
    down = '0;
    if (first_of_activity) begin
      lap_acc = cleared_stats();
      act_acc = cleared_stats();
      have_prev = 1'b0;
    end
    if (have_prev) begin
      d = v[3] - prev_ele;
      if (d > 0) up = d;
      else down = -d;
    end
    prev_ele = elevation_dm;
    have_prev = 1'b1;
    lap_acc = fold_sample(lap_acc, v, up, down);
    act_acc = fold_sample(act_acc, v, up, down);
    if (lap_end) begin
      queue_rows(lap_acc, 1'b0, !last_of_activity);
      lap_acc = cleared_stats();
    end
    if (last_of_activity) begin
      queue_rows(act_acc, 1'b1, 1'b1);
      act_acc = cleared_stats();
      have_prev = 1'b0;
      prev_ele = '0;
    end
  endtask

  task automatic check_row();
    summary_row_t w;
    if (summary_rows.size() == 0) begin
      report("unexpected row", channel, 0);
      return;
    end
    w = summary_rows.pop_front();
    if (scope !== w.scope) report("scope", scope, w.scope);
    if (channel !== w.channel) report("channel", channel, w.channel);
    if (maximum !== w.maximum) report("maximum", maximum, w.maximum);
    if (minimum !== w.minimum) report("minimum", minimum, w.minimum);
    if (average !== w.average) report("average", average, w.average);
    if (gain_dm !== w.gain) report("gain", gain_dm, w.gain);
    if (loss_dm !== w.loss) report("loss", loss_dm, w.loss);
    if (last_row !== w.last_row) report("last_row", last_row, w.last_row);
  endtask

  initial begin
    mismatches = 0;
    rows_pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      lap_acc = cleared_stats();
      act_acc = cleared_stats();
      prev_ele = '0;
      have_prev = 1'b0;
      summary_rows.delete();
    end else begin
      if (out_valid && !out_stall) check_row();
      if (in_valid && !in_stall) absorb_sample();
    end
    rows_pending = summary_rows.size();
  end
endmodule

// ===== sim/tb_track_point_summary_stats_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the track point summary statistics core: drives samples in
// bursts, stalls rows at random and gives the verdict. Depends on the checker.
module tb_track_point_summary_stats_core;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] cadence_rpm = '0;
  logic [7:0] heart_bpm = '0;
  logic [15:0] speed_mms = '0;
  logic signed [19:0] elevation_dm = '0;
  logic first_of_activity = 1'b0;
  logic last_of_lap = 1'b0;
  logic last_of_activity = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic scope;
  logic [1:0] channel;
  logic signed [19:0] maximum, minimum;
  logic [15:0] average;
  logic [31:0] gain_dm, loss_dm;
  logic last_row;
  int mismatches, rows_pending;
  int quiet_cycles = 0;
  bit stall_on = 1'b0;

  // an 8-row activity end, each row waiting on the divider and on stalls, stays well under this
  localparam int QuietLimit = 20000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  track_point_summary_stats_core dut (.*);

  track_point_summary_stats_checker u_checker (.*);

  // Receiver stall pattern: alternate long open stretches with choppy stalling.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_on <= !stall_on;
    out_stall <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b0;
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QuietLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Drive one sample and hold it until the core takes the beat.
  task automatic send_sample(logic [7:0] cad, logic [7:0] hr, logic [15:0] spd,
                             logic signed [19:0] ele, logic fst, logic lap, logic act);
    in_valid <= 1'b1;
    cadence_rpm <= cad;
    heart_bpm <= hr;
    speed_mms <= spd;
    elevation_dm <= ele;
    first_of_activity <= fst;
    last_of_lap <= lap;
    last_of_activity <= act;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Insert a random gap between bursts; drop valid only when a gap follows.
  task automatic maybe_pause(inout int burst_left);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_sample(logic fst, logic lap, logic act);
    logic [7:0] hr;
    logic signed [19:0] ele;
    hr = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom);
    case ($urandom_range(0, 3))
      0: ele = 20'($urandom);
      1: ele = ($urandom_range(0, 1) != 0) ? 20'sh7FFFF : 20'sh80000;
      default: ele = 20'sd1000 + $signed(20'($urandom_range(0, 400))) - 20'sd200;
    endcase
    send_sample(8'($urandom), hr, 16'($urandom), ele, fst, lap, act);
  endtask

  initial begin
    int burst_left;
    int sent;
    int lap_len;
    burst_left = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, zero heart rate, all end-mark combinations.
    send_sample(8'd0, 8'd0, 16'd0, 20'sh80000, 1'b1, 1'b0, 1'b0);
    send_sample(8'd255, 8'd255, 16'hFFFF, 20'sh7FFFF, 1'b0, 1'b0, 1'b0);
    send_sample(8'd10, 8'd0, 16'd5, 20'sh80000, 1'b0, 1'b1, 1'b0);
    send_sample(8'd1, 8'd0, 16'd1, 20'sd0, 1'b0, 1'b0, 1'b1);
    // heart rate all zero: unset minimum reported as zero
    send_sample(8'd7, 8'd0, 16'd300, 20'sd50, 1'b1, 1'b0, 1'b0);
    send_sample(8'd9, 8'd0, 16'd400, 20'sd40, 1'b0, 1'b1, 1'b0);
    // baseline carries across laps, activity end together with a lap mark
    send_sample(8'd20, 8'd60, 16'd1000, 20'sd45, 1'b0, 1'b0, 1'b0);
    send_sample(8'd21, 8'd61, 16'd1001, -20'sd45, 1'b0, 1'b1, 1'b1);
    // single-sample activity and a sample with no opening mark after an end
    send_sample(8'd255, 8'd1, 16'hFFFF, 20'sh7FFFF, 1'b1, 1'b1, 1'b1);
    send_sample(8'd3, 8'd2, 16'd2, 20'sd5, 1'b0, 1'b0, 1'b0);
    send_sample(8'd4, 8'd3, 16'd3, 20'sh80000, 1'b0, 1'b1, 1'b1);
    // opening mark in the middle of an open activity
    send_sample(8'd5, 8'd5, 16'd5, 20'sd100, 1'b0, 1'b0, 1'b0);
    send_sample(8'd6, 8'd6, 16'd6, 20'sd90, 1'b1, 1'b0, 1'b0);
    send_sample(8'd8, 8'd0, 16'd8, 20'sd120, 1'b0, 1'b1, 1'b1);

    // Hold off until every row is back, after a wait that lets the checker take the last beat.
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);

    // Random: mostly well-formed activities of short laps, some noise.
    while (sent < 96) begin
      if ($urandom_range(0, 5) == 0) begin
        random_sample(1'($urandom), 1'($urandom), 1'($urandom));
        sent++;
        maybe_pause(burst_left);
      end else begin
        for (int lap = $urandom_range(1, 3); lap > 0; lap--) begin
          lap_len = $urandom_range(1, 5);
          for (int i = 0; i < lap_len; i++) begin
            random_sample(lap == 3 && i == 0 ? 1'b1 : 1'b0, i == lap_len - 1 && lap > 1,
                          i == lap_len - 1 && lap == 1);
            sent++;
            maybe_pause(burst_left);
          end
        end
      end
      if (sent > 45 && sent < 52) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (rows_pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tpss_pkg.sv
hw/rtl/tpss_front.sv
hw/rtl/tpss_div.sv
hw/rtl/tpss_back.sv
hw/rtl/track_point_summary_stats_core.sv
sim/track_point_summary_stats_checker.sv
sim/tb_track_point_summary_stats_core.sv
